>>> design/sflo_pkg.sv
// shared widths, types and helpers for the struct field layout optimizer
package sflo_pkg;

	localparam int MAX_FIELDS_DEF = 32;
	localparam int BYTES_W        = 16;
	localparam int AL_W           = 13;
	localparam int CNT_IN_W       = 32;
	localparam int IDX_OUT_W      = 5;
	localparam int SZ_W           = 22;
	localparam int OFF_W          = 24;
	localparam int HB_W           = 23;
	localparam int CFG_IDX_W      = 1;
	localparam logic [SZ_W-1:0] SZ_MAX = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HOT_FIRST = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOA_HINT  = 1'd1;

	typedef struct packed {
		logic [BYTES_W-1:0]  field_bytes;
		logic [AL_W-1:0]     field_alignment;
		logic [CNT_IN_W-1:0] hit_count;
		logic                last_field;
	} field_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] original_index;
		logic [SZ_W-1:0]      field_offset;
		logic [BYTES_W-1:0]   out_bytes;
		logic [AL_W-1:0]      out_alignment;
		logic                 hot_flag;
		logic [SZ_W-1:0]      orig_size;
		logic [AL_W-1:0]      original_max_align;
		logic [SZ_W-1:0]      opt_size;
		logic [AL_W-1:0]      optimized_max_align;
		logic [SZ_W-1:0]      bytes_saved;
		logic                 soa_flag;
		logic                 last_result;
	} result_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic rank_start;
		logic rank_scan;
		logic rank_write;
		logic sum_init;
		logic emit_init;
		logic ord_rd;
		logic fld_rd;
		logic acc;
		logic emit;
		logic fin1;
		logic fin2;
		logic clear;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic scan_last;
		logic i_last;
		logic p_last;
		logic out_free;
	} stat_t;

	// round v up with mask a-1
	function automatic logic [OFF_W-1:0] round_up(input logic [OFF_W-1:0] v,
		input logic [AL_W-1:0] a);
		logic [OFF_W-1:0] m;
		m = OFF_W'(a - AL_W'(1));
		return (v + m) & ~m;
	endfunction

	// clamp to 22 bits
	function automatic logic [SZ_W-1:0] sat22(input logic [OFF_W-1:0] v);
		return (v > OFF_W'(SZ_MAX)) ? SZ_MAX : v[SZ_W-1:0];
	endfunction

endpackage

>>> design/sflo_if.sv
// channel interfaces: field input, result output, configuration write
interface sflo_field_if;
	import sflo_pkg::*;
	logic                valid;
	logic                ready;
	logic [BYTES_W-1:0]  field_bytes;
	logic [AL_W-1:0]     field_alignment;
	logic [CNT_IN_W-1:0] hit_count;
	logic                last_field;
	modport source(output valid, field_bytes, field_alignment, hit_count, last_field,
		input ready);
	modport sink(input valid, field_bytes, field_alignment, hit_count, last_field,
		output ready);
endinterface

interface sflo_result_if;
	import sflo_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [IDX_OUT_W-1:0] original_index;
	logic [SZ_W-1:0]      field_offset;
	logic [BYTES_W-1:0]   out_bytes;
	logic [AL_W-1:0]      out_alignment;
	logic                 hot_flag;
	logic [SZ_W-1:0]      orig_size;
	logic [AL_W-1:0]      original_max_align;
	logic [SZ_W-1:0]      opt_size;
	logic [AL_W-1:0]      optimized_max_align;
	logic [SZ_W-1:0]      bytes_saved;
	logic                 soa_flag;
	logic                 last_result;
	modport source(output valid, original_index, field_offset, out_bytes, out_alignment,
		hot_flag, orig_size, original_max_align, opt_size, optimized_max_align,
		bytes_saved, soa_flag, last_result, input ready);
	modport sink(input valid, original_index, field_offset, out_bytes, out_alignment,
		hot_flag, orig_size, original_max_align, opt_size, optimized_max_align,
		bytes_saved, soa_flag, last_result, output ready);
endinterface

interface sflo_cfg_if;
	import sflo_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic                 data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> design/struct_field_layout_optimizer_core.sv
// top level of the struct field layout optimizer
// Usage:
// - fields: one beat per struct field (bytes, alignment, access count,
//   last_field). Beats are taken one per cycle while the block is loading;
//   fields beyond MAX_FIELDS are dropped, but their last_field mark counts.
// - A beat with last_field set starts processing; fields.ready stays low
//   until the final result beat has entered the output register.
// - results: one beat per stored field, in sorted order (descending
//   alignment, hot before cold if enabled, then load order); struct totals
//   repeat on every beat and last_result marks the final one.
// - cfg: register writes (0 hot-first, 1 SOA hint), always ready, to be
//   written only while idle.
// Processing of a struct: loading, then ranking (one memory read per
// compare, each stored field compared against every stored field), a
// size pass, the finishing states FIN1 and FIN2, and an emit pass;
// all ranking goes through the single compare unit.
// Reset clears counters, running sums and handshake state; the field stores
// need no clearing. A stalled receiver holds the output register and
// pauses the emit pass; no result is lost.
module struct_field_layout_optimizer_core
	import sflo_pkg::*;
#(
	parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	sflo_field_if.sink   fields,
	sflo_result_if.source results,
	sflo_cfg_if.sink     cfg
);

	cmd_t    cmd;
	stat_t   st;
	field_t  fin;
	result_t res;

	assign fin.field_bytes     = fields.field_bytes;
	assign fin.field_alignment = fields.field_alignment;
	assign fin.hit_count       = fields.hit_count;
	assign fin.last_field      = fields.last_field;

	assign cfg.ready = 1'b1;

	sflo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fields.valid),
		.in_last  (fields.last_field),
		.in_ready (fields.ready),
		.st       (st),
		.cmd      (cmd)
	);

	sflo_dp #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.fin       (fin),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.res       (res)
	);

	// result beat fields
	assign results.original_index      = res.original_index;
	assign results.field_offset        = res.field_offset;
	assign results.out_bytes           = res.out_bytes;
	assign results.out_alignment       = res.out_alignment;
	assign results.hot_flag            = res.hot_flag;
	assign results.orig_size           = res.orig_size;
	assign results.original_max_align  = res.original_max_align;
	assign results.opt_size            = res.opt_size;
	assign results.optimized_max_align = res.optimized_max_align;
	assign results.bytes_saved         = res.bytes_saved;
	assign results.soa_flag            = res.soa_flag;
	assign results.last_result         = res.last_result;

endmodule

>>> design/sflo_ctrl.sv
// controller state machine: load, rank, size pass, finish, emit pass
module sflo_ctrl
	import sflo_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_last,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RK_A = 4'd1;
	localparam logic [3:0] S_RK_B = 4'd2;
	localparam logic [3:0] S_RK_D = 4'd3;
	localparam logic [3:0] S_RK_W = 4'd4;
	localparam logic [3:0] S_L_O  = 4'd5;
	localparam logic [3:0] S_L_F  = 4'd6;
	localparam logic [3:0] S_L_C  = 4'd7;
	localparam logic [3:0] S_FIN1 = 4'd8;
	localparam logic [3:0] S_FIN2 = 4'd9;
	localparam logic [3:0] S_E_O  = 4'd10;
	localparam logic [3:0] S_E_F  = 4'd11;
	localparam logic [3:0] S_E_C  = 4'd12;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) state_d = S_RK_A;
				end
			end
			S_RK_A: begin
				cmd.rank_start = 1'b1;
				state_d = S_RK_B;
			end
			S_RK_B: begin
				cmd.rank_scan = 1'b1;
				if (st.scan_last) state_d = S_RK_D;
			end
			S_RK_D: state_d = S_RK_W;
			S_RK_W: begin
				cmd.rank_write = 1'b1;
				if (st.i_last) begin
					cmd.sum_init = 1'b1;
					state_d = S_L_O;
				end else begin
					state_d = S_RK_A;
				end
			end
			S_L_O: begin
				cmd.ord_rd = 1'b1;
				state_d = S_L_F;
			end
			S_L_F: begin
				cmd.fld_rd = 1'b1;
				state_d = S_L_C;
			end
			S_L_C: begin
				cmd.acc = 1'b1;
				state_d = st.p_last ? S_FIN1 : S_L_O;
			end
			S_FIN1: begin
				cmd.fin1 = 1'b1;
				state_d = S_FIN2;
			end
			S_FIN2: begin
				cmd.fin2 = 1'b1;
				cmd.emit_init = 1'b1;
				state_d = S_E_O;
			end
			S_E_O: begin
				cmd.ord_rd = 1'b1;
				state_d = S_E_F;
			end
			S_E_F: begin
				cmd.fld_rd = 1'b1;
				state_d = S_E_C;
			end
			S_E_C: begin
				if (st.out_free) begin
					cmd.acc  = 1'b1;
					cmd.emit = 1'b1;
					if (st.p_last) begin
						cmd.clear = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_E_O;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/sflo_dp.sv
// datapath: field memory, order memory, rank counter, layout sums, result register
module sflo_dp
	import sflo_pkg::*;
#(
	parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                st,
	input  field_t               fin,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output result_t              res
);

	localparam int IDX_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
	localparam int CNT_W = $clog2(MAX_FIELDS + 1);
	localparam int MEM_W = AL_W + 1 + BYTES_W;

	// field memory {align, hot, bytes} and sorted order memory
	logic [MEM_W-1:0] fld_mem [MAX_FIELDS];
	logic [IDX_W-1:0] ord_mem [MAX_FIELDS];
	logic [MEM_W-1:0] rd_a_q, rd_b_q;
	logic [IDX_W-1:0] order_q;

	logic [CNT_W-1:0] n_q, hot_fields_q;
	logic [OFF_W-1:0] naive_off_q;
	logic [AL_W-1:0]  naive_al_q;
	logic [HB_W-1:0]  hot_bytes_q;
	logic [IDX_W-1:0] i_q, j_q, j_s1, rank_q, p_q;
	logic             b_vld_s1;
	logic [OFF_W-1:0] run_q, opt_size_q, orig_size_q, saved_q;
	logic [AL_W-1:0]  opt_al_q;
	logic             soa_q;
	logic             hot_first_q, soa_en_q;
	logic             out_vld_q;
	result_t          res_q;

	logic [AL_W-1:0]    in_al;
	logic               in_hot;
	logic [AL_W-1:0]    al_a, al_b;
	logic               hot_a, hot_b;
	logic [BYTES_W-1:0] sz_a;
	logic               j_ahead;
	logic [OFF_W-1:0]   cur_off;
	logic [IDX_W-1:0]   addr_a;

	assign in_al  = (fin.field_alignment == '0) ? AL_W'(1) : fin.field_alignment;
	assign in_hot = |fin.hit_count;
	assign al_a   = rd_a_q[MEM_W-1 -: AL_W];
	assign hot_a  = rd_a_q[BYTES_W];
	assign sz_a   = rd_a_q[BYTES_W-1:0];
	assign al_b   = rd_b_q[MEM_W-1 -: AL_W];
	assign hot_b  = rd_b_q[BYTES_W];
	assign addr_a = cmd.rank_start ? i_q : order_q;
	assign cur_off = round_up(run_q, al_a);

	// entry j goes before entry i
	always_comb begin
		if (al_b != al_a) begin
			j_ahead = al_b > al_a;
		end else if (hot_first_q && (hot_b != hot_a)) begin
			j_ahead = hot_b;
		end else begin
			j_ahead = j_s1 < i_q;
		end
	end

	assign st.scan_last = (CNT_W'(j_q) == (n_q - CNT_W'(1)));
	assign st.i_last    = (CNT_W'(i_q) == (n_q - CNT_W'(1)));
	assign st.p_last    = (CNT_W'(p_q) == (n_q - CNT_W'(1)));
	assign st.out_free  = !out_vld_q || out_ready;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.load && (n_q < CNT_W'(MAX_FIELDS))) begin
			fld_mem[n_q[IDX_W-1:0]] <= {in_al, in_hot, fin.field_bytes};
		end
		if (cmd.rank_start || cmd.fld_rd) begin
			rd_a_q <= fld_mem[addr_a];
		end
		if (cmd.rank_scan) begin
			rd_b_q <= fld_mem[j_q];
		end
		if (cmd.rank_write) begin
			ord_mem[rank_q] <= i_q;
		end
		if (cmd.ord_rd) begin
			order_q <= ord_mem[p_q];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hot_first_q <= 1'b1;
			soa_en_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HOT_FIRST: hot_first_q <= cfg_data;
				REG_SOA_HINT:  soa_en_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// load-order statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q          <= '0;
			naive_off_q  <= '0;
			naive_al_q   <= AL_W'(1);
			hot_bytes_q  <= '0;
			hot_fields_q <= '0;
		end else if (cmd.clear) begin
			n_q          <= '0;
			naive_off_q  <= '0;
			naive_al_q   <= AL_W'(1);
			hot_bytes_q  <= '0;
			hot_fields_q <= '0;
		end else if (cmd.load && (n_q < CNT_W'(MAX_FIELDS))) begin
			n_q         <= n_q + CNT_W'(1);
			naive_off_q <= round_up(naive_off_q, in_al) + OFF_W'(fin.field_bytes);
			if (in_al > naive_al_q) naive_al_q <= in_al;
			if (in_hot) begin
				hot_bytes_q  <= hot_bytes_q + HB_W'(fin.field_bytes);
				hot_fields_q <= hot_fields_q + CNT_W'(1);
			end
		end
	end

	// rank counting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q      <= '0;
			j_q      <= '0;
			j_s1     <= '0;
			rank_q   <= '0;
			b_vld_s1 <= 1'b0;
		end else begin
			b_vld_s1 <= cmd.rank_scan;
			if (cmd.rank_scan) begin
				j_s1 <= j_q;
				j_q  <= j_q + IDX_W'(1);
			end
			if (cmd.rank_start) begin
				j_q    <= '0;
				rank_q <= '0;
			end else if (b_vld_s1 && j_ahead) begin
				rank_q <= rank_q + IDX_W'(1);
			end
			if (cmd.clear) begin
				i_q <= '0;
			end else if (cmd.rank_write) begin
				i_q <= i_q + IDX_W'(1);
			end
		end
	end

	// layout passes and struct totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q      <= '0;
			run_q    <= '0;
			opt_al_q <= AL_W'(1);
		end else begin
			if (cmd.sum_init || cmd.emit_init || cmd.clear) begin
				p_q   <= '0;
				run_q <= '0;
			end else if (cmd.acc) begin
				p_q   <= p_q + IDX_W'(1);
				run_q <= cur_off + OFF_W'(sz_a);
			end
			if (cmd.sum_init) begin
				opt_al_q <= AL_W'(1);
			end else if (cmd.acc && !cmd.emit && (al_a > opt_al_q)) begin
				opt_al_q <= al_a;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin1) begin
			opt_size_q  <= round_up(run_q, opt_al_q);
			orig_size_q <= round_up(naive_off_q, naive_al_q);
		end
		if (cmd.fin2) begin
			saved_q <= (orig_size_q > opt_size_q) ? (orig_size_q - opt_size_q) : '0;
			soa_q   <= soa_en_q && (32'(n_q) >= 32'd3) && (hot_fields_q != '0) &&
				(hot_fields_q != n_q) && ({hot_bytes_q, 1'b0} < opt_size_q);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.original_index      <= IDX_OUT_W'(order_q);
			res_q.field_offset        <= sat22(cur_off);
			res_q.out_bytes           <= sz_a;
			res_q.out_alignment       <= al_a;
			res_q.hot_flag            <= hot_a;
			res_q.orig_size           <= sat22(orig_size_q);
			res_q.original_max_align  <= naive_al_q;
			res_q.opt_size            <= sat22(opt_size_q);
			res_q.optimized_max_align <= opt_al_q;
			res_q.bytes_saved         <= sat22(saved_q);
			res_q.soa_flag            <= soa_q;
			res_q.last_result         <= st.p_last;
		end
	end

	assign out_valid = out_vld_q;
	assign res       = res_q;

	// a new beat never overwrites one still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_vld_q || out_ready))
		else $error("result overwritten while stalled");

	// the field count never passes the store depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_FIELDS))
		else $error("field count beyond depth");

	// a rank written is inside the loaded fields
	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rank_write |-> (CNT_W'(rank_q) < n_q))
		else $error("rank out of range");

	// loads happen only while no struct is being processed
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (p_q == '0 && !b_vld_s1))
		else $error("load during processing");

endmodule
